// ----- hw/rtl/dq_pkg.sv -----
package dq_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_CLEAR      = 3'd4
   } dq_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } dq_status_type;

   typedef struct packed {
      logic [2:0]               req_type;
      logic signed [DATA_W-1:0] push_value;
   } dq_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic [CNT_W-1:0]         item_count;
      dq_status_type            status;
   } dq_rsp_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic              load;
      logic              shift_right;
      logic              shift_left;
      logic              write_back;
      logic [CNT_W-1:0]  new_count;
      logic [DATA_W-1:0] push_value;
   } dq_cell_cmd_type;

endpackage

// ----- hw/rtl/double_ended_queue.sv -----
// Double-ended queue of signed 32-bit values held in a row of cells.
// Input channel: drive req_payload and raise start; the transaction is taken
// at a rising edge with start high and busy low. busy stays low, so one
// transaction may enter in every cycle.
// Each transaction pushes at the back or front, pops from either end, or
// clears the queue; codes 5 to 7 change nothing.
// Result channel: one result per transaction, on rsp_payload for exactly one
// cycle with rsp_valid high, in the cycle after the transaction was taken.
// Throughput is one transaction per cycle: a push at the front or a pop at
// the front shifts the whole row of cells by one, and the back is picked by
// a one-hot flag per cell.
// The result holds the popped value, the front and back values and the
// count after the transaction, and a status: pop on empty or push on full
// leaves the queue unchanged.
// The receiver cannot stall; a result not taken in its cycle is lost.
// Reset (synchronous) empties the queue and drops any pending result.
module double_ended_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  dq_pkg::dq_req_type req_payload,
   output logic               rsp_valid,
   output dq_pkg::dq_rsp_type rsp_payload
);
   import dq_pkg::*;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] popped_ff;
   logic [DATA_W-1:0] popped_in;
   dq_status_type     status_ff;
   dq_status_type     status_in;
   dq_cell_cmd_type   cmd;
   logic [DATA_W-1:0] front_data;
   logic [DATA_W-1:0] back_data;
   logic              accept;
   logic              is_empty;
   logic              is_full;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_empty = count_ff == '0;
   assign is_full  = count_ff == CNT_W'(DEPTH);

   always_comb begin
      count_in        = count_ff;
      popped_in       = '0;
      status_in       = ST_OK;
      cmd.load        = accept;
      cmd.shift_right = 1'b0;
      cmd.shift_left  = 1'b0;
      cmd.write_back  = 1'b0;
      cmd.push_value  = req_payload.push_value;
      if (accept) begin
         unique case (req_payload.req_type)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  if (req_payload.req_type == OP_PUSH_BACK) begin
                     cmd.write_back = 1'b1;
                  end else begin
                     cmd.shift_right = 1'b1;
                  end
               end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  if (req_payload.req_type == OP_POP_BACK) begin
                     popped_in = back_data;
                  end else begin
                     popped_in = front_data;
                     cmd.shift_left = 1'b1;
                  end
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
      cmd.new_count = count_in;
   end

   dq_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .front_data (front_data),
      .back_data  (back_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff <= popped_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_payload.popped_value = popped_ff;
   assign rsp_payload.front_value  = is_empty ? '0 : front_data;
   assign rsp_payload.back_value   = back_data;
   assign rsp_payload.item_count   = count_ff;
   assign rsp_payload.status       = status_ff;

endmodule

// ----- hw/rtl/dq_cell.sv -----
module dq_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dq_pkg::IDX_W-1:0]      cell_index,
   input  dq_pkg::dq_cell_cmd_type       cmd,
   input  logic [dq_pkg::DATA_W-1:0]     left_data,
   input  logic [dq_pkg::DATA_W-1:0]     right_data,
   output logic [dq_pkg::DATA_W-1:0]     data_out,
   output logic                          last_out
);
   import dq_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              last_ff;
   logic              last_in;

   // this cell holds the back value once the count settles
   assign last_in = (CNT_W'(cell_index) + CNT_W'(1)) == cmd.new_count;

   always_comb begin
      data_in = data_ff;
      priority if (cmd.shift_right) begin
         data_in = left_data;
      end else if (cmd.shift_left) begin
         data_in = right_data;
      end else if (cmd.write_back && last_in) begin
         data_in = cmd.push_value;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (cmd.load) begin
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign last_out = last_ff;

endmodule

// ----- hw/rtl/dq_chain.sv -----
module dq_chain (
   input  logic                      clock,
   input  logic                      reset,
   input  dq_pkg::dq_cell_cmd_type   cmd,
   output logic [dq_pkg::DATA_W-1:0] front_data,
   output logic [dq_pkg::DATA_W-1:0] back_data
);
   import dq_pkg::*;

   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]  cell_last;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      // the front cell shifts in the pushed value, the far end holds itself
      if (i == 0) begin : g_head
         assign left_data = cmd.push_value;
      end else begin : g_body
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_data = cell_data[i];
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end

      dq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data_out   (cell_data[i]),
         .last_out   (cell_last[i])
      );
   end

   // one-hot select of the back cell; no flag set when empty gives zero
   always_comb begin
      back_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_data = back_data | (cell_data[i] & {DATA_W{cell_last[i]}});
      end
   end

   assign front_data = cell_data[0];

endmodule
